// ----- rtl/coap_pkg.sv -----
// ----------------------------------------------------------------------------
// coap_pkg
// Shared types and constants for the CoAP message parser.
// ----------------------------------------------------------------------------
package coap_pkg;

  localparam int LEN_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_OPTIONS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_MSG_LEN = 1'b1;

  localparam logic [7:0]       MAX_OPTIONS_RST = 8'd10;
  localparam logic [LEN_W-1:0] MAX_MSG_LEN_RST = 10'd159;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_TOKEN     = 3'd1;
  localparam logic [2:0] KIND_OPT_HEAD  = 3'd2;
  localparam logic [2:0] KIND_OPT_BYTE  = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd4;
  localparam logic [2:0] KIND_ACCEPTED  = 3'd5;
  localparam logic [2:0] KIND_DROPPED   = 3'd6;
  localparam logic [2:0] KIND_MALFORMED = 3'd7;

  typedef struct packed {
    logic [2:0]       kind;
    logic             last_of_run;
    logic [1:0]       msg_type;
    logic [3:0]       token_len;
    logic [7:0]       code;
    logic [15:0]      message_id;
    logic [15:0]      option_number;
    logic [LEN_W-1:0] option_length;
    logic [7:0]       data_out;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ----- rtl/coap_parse_core.sv -----
// ----------------------------------------------------------------------------
// coap_parse_core
// Per-byte parse state machine; produces up to two result beats per byte.
// ----------------------------------------------------------------------------
module coap_parse_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [7:0]                     in_data,
  input  logic                           in_last,
  input  logic                           cfg_we,
  input  logic [coap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [coap_pkg::CFG_DATA_W-1:0] cfg_data,
  output coap_pkg::push_t                push
);

  localparam logic [3:0] PH_HDR     = 4'd0;
  localparam logic [3:0] PH_TOKEN   = 4'd1;
  localparam logic [3:0] PH_OPT     = 4'd2;
  localparam logic [3:0] PH_DEXT1   = 4'd3;
  localparam logic [3:0] PH_DEXT2A  = 4'd4;
  localparam logic [3:0] PH_DEXT2B  = 4'd5;
  localparam logic [3:0] PH_LEXT1   = 4'd6;
  localparam logic [3:0] PH_LEXT2A  = 4'd7;
  localparam logic [3:0] PH_LEXT2B  = 4'd8;
  localparam logic [3:0] PH_VALUE   = 4'd9;
  localparam logic [3:0] PH_PAYLOAD = 4'd10;
  localparam logic [3:0] PH_IGNORE  = 4'd11;

  localparam logic [1:0] OUT_GOOD      = 2'd0;
  localparam logic [1:0] OUT_DROPPED   = 2'd1;
  localparam logic [1:0] OUT_MALFORMED = 2'd2;

  localparam int LW = coap_pkg::LEN_W;

  logic [7:0]    max_opts_r;
  logic [LW-1:0] max_len_r;

  logic [3:0]    phase_r,      phase_nxt;
  logic [LW-1:0] byte_count_r, byte_count_nxt;
  logic [31:0]   header_r,     header_nxt;
  logic [LW-1:0] bytes_left_r, bytes_left_nxt;
  logic [15:0]   run_num_r,    run_num_nxt;
  logic [3:0]    len_nib_r,    len_nib_nxt;
  logic [7:0]    ext_hi_r,     ext_hi_nxt;
  logic [LW-1:0] opt_len_r,    opt_len_nxt;
  logic [7:0]    opt_count_r,  opt_count_nxt;
  logic [1:0]    outcome_r,    outcome_nxt;

  always_comb begin
    logic              consumed;
    logic [LW-1:0]     cnt_new;
    logic [LW-1:0]     room;
    logic [31:0]       hdr_new;
    logic [16:0]       delta;
    logic [16:0]       len_full;
    logic [15:0]       run_sum;
    logic [3:0]        nib;
    logic              do_delta;
    logic              do_head;
    logic              emit;
    coap_pkg::result_t emit_res;
    coap_pkg::result_t verdict_res;

    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    header_nxt     = header_r;
    bytes_left_nxt = bytes_left_r;
    run_num_nxt    = run_num_r;
    len_nib_nxt    = len_nib_r;
    ext_hi_nxt     = ext_hi_r;
    opt_len_nxt    = opt_len_r;
    opt_count_nxt  = opt_count_r;
    outcome_nxt    = outcome_r;

    consumed = en && (byte_count_r < max_len_r);
    cnt_new  = byte_count_r + 1'b1;
    room     = max_len_r - cnt_new;
    hdr_new  = {header_r[23:0], in_data};
    delta    = '0;
    len_full = '0;
    nib      = len_nib_r;
    do_delta = 1'b0;
    do_head  = 1'b0;
    emit     = 1'b0;
    emit_res = '0;

    if (consumed) begin
      byte_count_nxt = cnt_new;
      unique case (phase_r)
        PH_HDR: begin
          header_nxt = hdr_new;
          if (byte_count_r == 10'd3) begin
            if (hdr_new[31:30] != 2'd1 || hdr_new[27:24] > 4'd8) begin
              outcome_nxt = OUT_DROPPED;
              phase_nxt   = PH_IGNORE;
            end else begin
              bytes_left_nxt     = {6'd0, hdr_new[27:24]};
              phase_nxt          = (hdr_new[27:24] != 4'd0) ? PH_TOKEN : PH_OPT;
              emit               = 1'b1;
              emit_res.kind      = coap_pkg::KIND_HEADER;
              emit_res.msg_type  = hdr_new[29:28];
              emit_res.token_len = hdr_new[27:24];
              emit_res.code      = hdr_new[23:16];
              emit_res.message_id = hdr_new[15:0];
            end
          end
        end
        PH_TOKEN: begin
          bytes_left_nxt = bytes_left_r - 1'b1;
          if (bytes_left_nxt == '0) phase_nxt = PH_OPT;
          emit              = 1'b1;
          emit_res.kind     = coap_pkg::KIND_TOKEN;
          emit_res.data_out = in_data;
        end
        PH_OPT: begin
          if (in_data == 8'hFF) begin
            phase_nxt = PH_PAYLOAD;
          end else if (opt_count_r >= max_opts_r) begin
            phase_nxt = PH_IGNORE;
          end else if (in_data[7:4] == 4'd15 || in_data[3:0] == 4'd15) begin
            outcome_nxt = OUT_MALFORMED;
            phase_nxt   = PH_IGNORE;
          end else begin
            len_nib_nxt = in_data[3:0];
            nib         = in_data[3:0];
            if (in_data[7:4] == 4'd13) begin
              phase_nxt = PH_DEXT1;
            end else if (in_data[7:4] == 4'd14) begin
              phase_nxt = PH_DEXT2A;
            end else begin
              do_delta = 1'b1;
              delta    = {13'd0, in_data[7:4]};
            end
          end
        end
        PH_DEXT1: begin
          do_delta = 1'b1;
          delta    = {9'd0, in_data} + 17'd13;
        end
        PH_DEXT2A: begin
          ext_hi_nxt = in_data;
          phase_nxt  = PH_DEXT2B;
        end
        PH_DEXT2B: begin
          do_delta = 1'b1;
          delta    = {1'b0, ext_hi_r, in_data} + 17'd269;
        end
        PH_LEXT1: begin
          do_head  = 1'b1;
          len_full = {9'd0, in_data} + 17'd13;
        end
        PH_LEXT2A: begin
          ext_hi_nxt = in_data;
          phase_nxt  = PH_LEXT2B;
        end
        PH_LEXT2B: begin
          do_head  = 1'b1;
          len_full = {1'b0, ext_hi_r, in_data} + 17'd269;
        end
        PH_VALUE: begin
          bytes_left_nxt = bytes_left_r - 1'b1;
          if (bytes_left_nxt == '0) phase_nxt = PH_OPT;
          emit                   = 1'b1;
          emit_res.kind          = coap_pkg::KIND_OPT_BYTE;
          emit_res.option_number = run_num_r;
          emit_res.option_length = opt_len_r;
          emit_res.data_out      = in_data;
        end
        PH_PAYLOAD: begin
          emit              = 1'b1;
          emit_res.kind     = coap_pkg::KIND_PAYLOAD;
          emit_res.data_out = in_data;
        end
        default: ;
      endcase

      run_sum = run_num_r + delta[15:0];
      if (do_delta) begin
        run_num_nxt = run_sum;
        if (nib == 4'd13) begin
          phase_nxt = PH_LEXT1;
        end else if (nib == 4'd14) begin
          phase_nxt = PH_LEXT2A;
        end else begin
          do_head  = 1'b1;
          len_full = {13'd0, nib};
        end
      end

      if (do_head) begin
        if (len_full > {7'd0, room}) begin
          outcome_nxt = OUT_MALFORMED;
          phase_nxt   = PH_IGNORE;
        end else begin
          opt_len_nxt            = len_full[LW-1:0];
          bytes_left_nxt         = len_full[LW-1:0];
          opt_count_nxt          = opt_count_r + 1'b1;
          phase_nxt              = (len_full == '0) ? PH_OPT : PH_VALUE;
          emit                   = 1'b1;
          emit_res.kind          = coap_pkg::KIND_OPT_HEAD;
          emit_res.option_number = run_num_nxt;
          emit_res.option_length = len_full[LW-1:0];
        end
      end
    end else begin
      run_sum = run_num_r;
    end

    verdict_res             = '0;
    verdict_res.last_of_run = 1'b1;
    if (outcome_nxt == OUT_DROPPED) begin
      verdict_res.kind = coap_pkg::KIND_DROPPED;
    end else if (outcome_nxt != OUT_GOOD) begin
      verdict_res.kind = coap_pkg::KIND_MALFORMED;
    end else if (phase_nxt == PH_HDR) begin
      verdict_res.kind = coap_pkg::KIND_DROPPED;
    end else if (phase_nxt == PH_OPT || phase_nxt == PH_PAYLOAD ||
                 phase_nxt == PH_IGNORE) begin
      verdict_res.kind = coap_pkg::KIND_ACCEPTED;
    end else begin
      verdict_res.kind = coap_pkg::KIND_MALFORMED;
    end

    push = '0;
    if (emit) begin
      push.r0             = emit_res;
      push.r0.last_of_run = ~in_last;
      push.n              = 2'd1;
      if (in_last) begin
        push.r1 = verdict_res;
        push.n  = 2'd2;
      end
    end else if (en && in_last) begin
      push.r0 = verdict_res;
      push.n  = 2'd1;
    end

    if (en && in_last) begin
      phase_nxt      = PH_HDR;
      byte_count_nxt = '0;
      header_nxt     = '0;
      bytes_left_nxt = '0;
      run_num_nxt    = '0;
      len_nib_nxt    = '0;
      ext_hi_nxt     = '0;
      opt_len_nxt    = '0;
      opt_count_nxt  = '0;
      outcome_nxt    = OUT_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_opts_r   <= coap_pkg::MAX_OPTIONS_RST;
      max_len_r    <= coap_pkg::MAX_MSG_LEN_RST;
      phase_r      <= PH_HDR;
      byte_count_r <= '0;
      header_r     <= '0;
      bytes_left_r <= '0;
      run_num_r    <= '0;
      len_nib_r    <= '0;
      ext_hi_r     <= '0;
      opt_len_r    <= '0;
      opt_count_r  <= '0;
      outcome_r    <= OUT_GOOD;
    end else begin
      if (cfg_we) begin
        if (cfg_index == coap_pkg::CFG_IDX_MAX_OPTIONS) max_opts_r <= cfg_data[7:0];
        if (cfg_index == coap_pkg::CFG_IDX_MAX_MSG_LEN) max_len_r  <= cfg_data[LW-1:0];
      end
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      header_r     <= header_nxt;
      bytes_left_r <= bytes_left_nxt;
      run_num_r    <= run_num_nxt;
      len_nib_r    <= len_nib_nxt;
      ext_hi_r     <= ext_hi_nxt;
      opt_len_r    <= opt_len_nxt;
      opt_count_r  <= opt_count_nxt;
      outcome_r    <= outcome_nxt;
    end
  end

  a_two_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !in_last) |-> (push.n != 2'd2))
    else $error("two result beats from a byte that is not last");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (en && in_last) |=> (phase_r == PH_HDR && byte_count_r == '0 && outcome_r == OUT_GOOD))
    else $error("message state not cleared after last byte");

  a_fail_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (outcome_r != OUT_GOOD) |-> (phase_r == PH_IGNORE))
    else $error("failed message not parked in ignore phase");

endmodule

// ----- rtl/coap_result_fifo.sv -----
// ----------------------------------------------------------------------------
// coap_result_fifo
// Small result queue: takes up to two beats per cycle, drains one while out_ready is high.
// ----------------------------------------------------------------------------
module coap_result_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  coap_pkg::push_t             push,
  output logic                        room,
  output logic                        out_valid,
  input  logic                        out_ready,
  output coap_pkg::result_t           out_res
);

  coap_pkg::result_t mem_r [coap_pkg::FIFO_DEPTH];

  logic [coap_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [coap_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [coap_pkg::CNT_W-1:0] count_r,  count_nxt;
  logic [coap_pkg::PTR_W-1:0] wr_ptr_p1;
  logic                       pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  assign room      = (count_r <= coap_pkg::CNT_W'(coap_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + coap_pkg::PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + coap_pkg::PTR_W'(pop);
    count_nxt  = count_r + coap_pkg::CNT_W'(push.n) - coap_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r]  <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/coap_message_parser.sv -----
// ----------------------------------------------------------------------------
// coap_message_parser
// CoAP datagram parser: one byte per beat in, header/token/option/payload
// and end-of-message result beats out.
// ----------------------------------------------------------------------------
// Path: each input beat goes through the input register, then the parse
//   step writes its results into the result queue.
// Throughput: one byte per cycle while out_ready is high and each byte yields
//   at most one result; the last byte of a datagram can yield two, drained one per cycle.
// Reset: synchronous, active low; parse state clears, max_options = 10,
//   max_message_len = 159.
// ----------------------------------------------------------------------------
module coap_message_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_kind,
  output logic                            out_last_of_run,
  output logic [1:0]                      out_msg_type,
  output logic [3:0]                      out_token_len,
  output logic [7:0]                      out_code,
  output logic [15:0]                     out_message_id,
  output logic [15:0]                     out_option_number,
  output logic [coap_pkg::LEN_W-1:0]      out_option_length,
  output logic [7:0]                      out_data_out,
  input  logic                            cfg_we,
  input  logic [coap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [coap_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic              s1_valid_r;
  logic [7:0]        s1_data_r;
  logic              s1_last_r;
  logic              room;
  logic              s1_go;
  coap_pkg::push_t   push;
  coap_pkg::result_t out_res;

  assign s1_go    = s1_valid_r & room;
  assign in_ready = ~s1_valid_r | room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  coap_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (s1_go),
    .in_data   (s1_data_r),
    .in_last   (s1_last_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  coap_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_last_of_run   = out_res.last_of_run;
  assign out_msg_type      = out_res.msg_type;
  assign out_token_len     = out_res.token_len;
  assign out_code          = out_res.code;
  assign out_message_id    = out_res.message_id;
  assign out_option_number = out_res.option_number;
  assign out_option_length = out_res.option_length;
  assign out_data_out      = out_res.data_out;

endmodule

// ----- test/coap_message_parser_tb.sv -----
// ----------------------------------------------------------------------------
// coap_message_parser testbench
// Feeds CoAP datagrams one byte per beat and predicts every result beat
// (header, token, option head and value, payload, end verdict) with a
// parse model kept in step with the register settings. A short table of
// hand-built datagrams runs first, then random datagrams, mostly well formed
// with some truncated, corrupted or pure noise, over several settings and
// three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [3:0] {
    ST_HDR, ST_TOKEN, ST_OPT, ST_DEXT1, ST_DEXT2A, ST_DEXT2B,
    ST_LEXT1, ST_LEXT2A, ST_LEXT2B, ST_VALUE, ST_PAYLOAD, ST_SKIP
  } stage_t;

  typedef enum logic [1:0] {MSG_GOOD, MSG_DROPPED, MSG_MALFORMED} outcome_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pin_en;
    logic [2:0] pin_kind;
  } beat_t;

  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_BEATS  = 75;
  localparam int N_PHASES     = 6;
  localparam int PHASE_OPTS [N_PHASES] = '{1, 255, 3, 0, 255, 2};
  localparam int PHASE_LEN  [N_PHASES] = '{1023, 5, 40, 3, 1023, 24};

  localparam beat_t DIRECTED [25] = '{
    '{8'h40, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h01, 1'b1, 1'b1, coap_pkg::KIND_DROPPED},
    '{8'hCF, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b1, 1'b1, coap_pkg::KIND_DROPPED},
    '{8'h40, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b1, 1'b1, coap_pkg::KIND_ACCEPTED},
    '{8'h71, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'hFF, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'hFF, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'hFF, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'hAB, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'hD1, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h5A, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'hFF, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b1, 1'b1, coap_pkg::KIND_ACCEPTED},
    '{8'h40, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'h00, 1'b0, 1'b0, coap_pkg::KIND_HEADER},
    '{8'hF0, 1'b1, 1'b1, coap_pkg::KIND_MALFORMED}
  };

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_data_byte = 8'h00;
  logic                            in_last_byte = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [2:0]                      out_kind;
  logic                            out_last_of_run;
  logic [1:0]                      out_msg_type;
  logic [3:0]                      out_token_len;
  logic [7:0]                      out_code;
  logic [15:0]                     out_message_id;
  logic [15:0]                     out_option_number;
  logic [coap_pkg::LEN_W-1:0]      out_option_length;
  logic [7:0]                      out_data_out;
  logic                            cfg_we = 1'b0;
  logic [coap_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [coap_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic       beat_pin_en = 1'b0;
  logic [2:0] beat_pin_kind = coap_pkg::KIND_HEADER;

  coap_message_parser dut (.*);

  initial forever #4 clk = ~clk;

  // parse model state and its copy of the registers
  logic [7:0]                 lim_options = coap_pkg::MAX_OPTIONS_RST;
  logic [coap_pkg::LEN_W-1:0] lim_len = coap_pkg::MAX_MSG_LEN_RST;
  stage_t                     stage;
  outcome_t                   outcome;
  int unsigned                nbytes, remaining, ext_val, opt_seen;
  logic [31:0]                hdr;
  logic [15:0]                opt_num;
  logic [3:0]                 len_nib;

  coap_pkg::result_t beat_results[$];
  coap_pkg::result_t expected_results[$];
  beat_t             stim_q[$];
  beat_t             next_beat;

  int unsigned send_idle_pct = 33, recv_idle_pct = 58;
  int unsigned beats_queued = 0, beats_taken = 0, results_seen = 0, datagrams = 0;
  int unsigned n_accept = 0, n_drop = 0, n_malf = 0, errors = 0, quiet = 0;

  function automatic coap_pkg::result_t blank_result(logic [2:0] kind);
    coap_pkg::result_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

  function void clear_message();
    stage = ST_HDR;
    outcome = MSG_GOOD;
    nbytes = 0;
    remaining = 0;
    ext_val = 0;
    opt_seen = 0;
    hdr = '0;
    opt_num = '0;
    len_nib = '0;
  endfunction

  function void give_up(outcome_t why);
    outcome = why;
    stage = ST_SKIP;
  endfunction

  function void close_option_head(int unsigned len);
    coap_pkg::result_t r;
    if (len > lim_len - nbytes) begin
      give_up(MSG_MALFORMED);
      return;
    end
    ext_val = len;
    remaining = len;
    opt_seen = (opt_seen + 1) & 8'hFF;
    stage = (len == 0) ? ST_OPT : ST_VALUE;
    r = blank_result(coap_pkg::KIND_OPT_HEAD);
    r.option_number = opt_num;
    r.option_length = coap_pkg::LEN_W'(len);
    beat_results.push_back(r);
  endfunction

  function void add_delta(int unsigned d);
    opt_num = opt_num + 16'(d);
    ext_val = 0;
    if (len_nib == 4'd13) stage = ST_LEXT1;
    else if (len_nib == 4'd14) stage = ST_LEXT2A;
    else close_option_head(len_nib);
  endfunction

  function void parse_one(logic [7:0] b);
    coap_pkg::result_t r;
    logic [3:0] tkl, dn;
    case (stage)
      ST_HDR: begin
        hdr = {hdr[23:0], b};
        if (nbytes < 4) return;
        tkl = hdr[27:24];
        if (hdr[31:30] != 2'b01 || tkl > 4'd8) begin
          give_up(MSG_DROPPED);
        end else begin
          remaining = tkl;
          stage = (tkl != 0) ? ST_TOKEN : ST_OPT;
          r = blank_result(coap_pkg::KIND_HEADER);
          r.msg_type = hdr[29:28];
          r.token_len = tkl;
          r.code = hdr[23:16];
          r.message_id = hdr[15:0];
          beat_results.push_back(r);
        end
      end
      ST_TOKEN: begin
        remaining = (remaining - 1) & 16'hFFFF;
        if (remaining == 0) stage = ST_OPT;
        r = blank_result(coap_pkg::KIND_TOKEN);
        r.data_out = b;
        beat_results.push_back(r);
      end
      ST_OPT: begin
        dn = b[7:4];
        len_nib = b[3:0];
        if (b == 8'hFF) stage = ST_PAYLOAD;
        else if (opt_seen >= lim_options) stage = ST_SKIP;
        else if (dn == 4'd15 || len_nib == 4'd15) give_up(MSG_MALFORMED);
        else if (dn == 4'd13) stage = ST_DEXT1;
        else if (dn == 4'd14) stage = ST_DEXT2A;
        else add_delta(dn);
      end
      ST_DEXT1: add_delta(b + 13);
      ST_DEXT2A: begin
        ext_val = b << 8;
        stage = ST_DEXT2B;
      end
      ST_DEXT2B: add_delta((ext_val | b) + 269);
      ST_LEXT1: close_option_head(b + 13);
      ST_LEXT2A: begin
        ext_val = b << 8;
        stage = ST_LEXT2B;
      end
      ST_LEXT2B: close_option_head((ext_val | b) + 269);
      ST_VALUE: begin
        remaining = (remaining - 1) & 16'hFFFF;
        if (remaining == 0) stage = ST_OPT;
        r = blank_result(coap_pkg::KIND_OPT_BYTE);
        r.option_number = opt_num;
        r.option_length = coap_pkg::LEN_W'(ext_val);
        r.data_out = b;
        beat_results.push_back(r);
      end
      ST_PAYLOAD: begin
        r = blank_result(coap_pkg::KIND_PAYLOAD);
        r.data_out = b;
        beat_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function logic [2:0] end_kind();
    if (outcome == MSG_DROPPED) return coap_pkg::KIND_DROPPED;
    if (outcome != MSG_GOOD) return coap_pkg::KIND_MALFORMED;
    case (stage) inside
      ST_HDR: return coap_pkg::KIND_DROPPED;
      ST_OPT, ST_PAYLOAD, ST_SKIP: return coap_pkg::KIND_ACCEPTED;
      default: return coap_pkg::KIND_MALFORMED;
    endcase
  endfunction

  function void parse_byte(logic [7:0] b, logic last);
    beat_results.delete();
    if (nbytes < lim_len) begin
      nbytes++;
      parse_one(b);
    end
    if (last) begin
      beat_results.push_back(blank_result(end_kind()));
      clear_message();
    end
    if (beat_results.size() != 0) beat_results[beat_results.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got,
               want);
  endtask

  task automatic check_result(coap_pkg::result_t got);
    coap_pkg::result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report("unexpected result, kind", got.kind, 0);
      return;
    end
    want = expected_results.pop_front();
    if (got.kind != want.kind) report("kind", got.kind, want.kind);
    if (got.last_of_run != want.last_of_run)
      report("last_of_run", got.last_of_run, want.last_of_run);
    if (got.msg_type != want.msg_type) report("msg_type", got.msg_type, want.msg_type);
    if (got.token_len != want.token_len) report("token_len", got.token_len, want.token_len);
    if (got.code != want.code) report("code", got.code, want.code);
    if (got.message_id != want.message_id)
      report("message_id", got.message_id, want.message_id);
    if (got.option_number != want.option_number)
      report("option_number", got.option_number, want.option_number);
    if (got.option_length != want.option_length)
      report("option_length", got.option_length, want.option_length);
    if (got.data_out != want.data_out) report("data_out", got.data_out, want.data_out);
    case (want.kind)
      coap_pkg::KIND_ACCEPTED:  n_accept++;
      coap_pkg::KIND_DROPPED:   n_drop++;
      coap_pkg::KIND_MALFORMED: n_malf++;
      default: ;
    endcase
  endtask

  // sender: hold the beat until taken, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = stim_q.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= next_beat.data;
        in_last_byte <= next_beat.last;
        beat_pin_en <= next_beat.pin_en;
        beat_pin_kind <= next_beat.pin_kind;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_message();
      lim_options = coap_pkg::MAX_OPTIONS_RST;
      lim_len = coap_pkg::MAX_MSG_LEN_RST;
      quiet = 0;
    end else begin
      if (out_valid && out_ready)
        check_result({out_kind, out_last_of_run, out_msg_type, out_token_len, out_code,
                      out_message_id, out_option_number, out_option_length, out_data_out});
      if (cfg_we) begin
        if (cfg_index == coap_pkg::CFG_IDX_MAX_OPTIONS) lim_options = cfg_data[7:0];
        else if (cfg_index == coap_pkg::CFG_IDX_MAX_MSG_LEN) lim_len = cfg_data;
      end
      if (in_valid && in_ready) begin
        beats_taken++;
        parse_byte(in_data_byte, in_last_byte);
        if (beat_pin_en && beat_results[beat_results.size() - 1].kind != beat_pin_kind)
          report("table verdict", beat_results[beat_results.size() - 1].kind, beat_pin_kind);
        foreach (beat_results[i]) expected_results.push_back(beat_results[i]);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("coap_message_parser regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [coap_pkg::CFG_IDX_W-1:0] idx,
                           logic [coap_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (beats_taken != beats_queued || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_datagram(int unsigned len_cap);
    logic [7:0] d[$];
    int unsigned tkl, nopt, sel, dn, ln, len, ext, keep;
    if ($urandom_range(24) == 0) begin
      repeat ($urandom_range(12, 1)) d.push_back(8'($urandom));
    end else begin
      tkl = ($urandom_range(19) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 0);
      d.push_back({($urandom_range(19) == 0) ? 2'($urandom) : 2'b01, 2'($urandom), 4'(tkl)});
      repeat (3 + tkl) d.push_back(8'($urandom));
      nopt = ($urandom_range(7) == 0) ? $urandom_range(14) : $urandom_range(3);
      repeat (nopt) begin
        sel = $urandom_range(99);
        dn = (sel < 60) ? $urandom_range(12) : (sel < 80) ? 13 : (sel < 97) ? 14 : 15;
        sel = $urandom_range(99);
        ln = (sel < 70) ? $urandom_range(12) : (sel < 90) ? 13 : (sel < 97) ? 14 : 15;
        if (dn == 15 && ln == 15) ln = 0;
        d.push_back({4'(dn), 4'(ln)});
        if (dn == 13) d.push_back(8'($urandom));
        if (dn == 14) begin
          d.push_back(8'($urandom));
          d.push_back(8'($urandom));
        end
        len = ln;
        if (ln == 13) begin
          ext = $urandom_range(30);
          d.push_back(8'(ext));
          len = ext + 13;
        end
        if (ln == 14) begin
          ext = (len_cap >= 300 && $urandom_range(3) == 0) ? $urandom_range(20)
                                                            : $urandom_range(65535);
          d.push_back(8'(ext >> 8));
          d.push_back(8'(ext));
          len = ext + 269;
        end
        repeat ((len > 300) ? $urandom_range(4) : len) d.push_back(8'($urandom));
      end
      if ($urandom_range(2) != 0) begin
        d.push_back(8'hFF);
        repeat ($urandom_range(8)) d.push_back(8'($urandom));
      end
      if ($urandom_range(9) == 0) begin
        keep = $urandom_range(d.size(), 1);
        while (d.size() > keep) void'(d.pop_back());
      end
      if ($urandom_range(19) == 0) d[$urandom_range(d.size() - 1)] = 8'($urandom);
    end
    foreach (d[i]) stim_q.push_back('{d[i], i == d.size() - 1, 1'b0, coap_pkg::KIND_HEADER});
    beats_queued += d.size();
    datagrams++;
  endtask

  initial begin
    int unsigned target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    foreach (DIRECTED[i]) begin
      stim_q.push_back(DIRECTED[i]);
      if (DIRECTED[i].last) datagrams++;
    end
    beats_queued += $size(DIRECTED);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(coap_pkg::CFG_IDX_MAX_OPTIONS, coap_pkg::CFG_DATA_W'(PHASE_OPTS[p]));
      write_reg(coap_pkg::CFG_IDX_MAX_MSG_LEN, coap_pkg::CFG_DATA_W'(PHASE_LEN[p]));
      @(negedge clk);
      send_idle_pct = (p < 2) ? 33 : (p < 4) ? 58 : 0;
      recv_idle_pct = (p < 2) ? 58 : (p < 4) ? 33 : 0;
      target = beats_queued + PHASE_BEATS;
      while (beats_queued < target) queue_datagram(PHASE_LEN[p]);
      wait_drained();
    end

    $display("checked %0d result beats from %0d input beats in %0d datagrams",
             results_seen, beats_taken, datagrams);
    $display("endings: %0d accepted, %0d dropped, %0d malformed over %0d register settings",
             n_accept, n_drop, n_malf, N_PHASES + 1);
    if (errors == 0) $display("coap_message_parser regression: pass");
    else $display("coap_message_parser regression: fail");
    $finish;
  end

endmodule

// ----- coap_message_parser.f -----
rtl/coap_pkg.sv
rtl/coap_parse_core.sv
rtl/coap_result_fifo.sv
rtl/coap_message_parser.sv
test/coap_message_parser_tb.sv
